// ----- hw/rtl/masked_sprite_blitter_assert.svh -----
// Assertion macros for the masked sprite blitter RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef MASKED_SPRITE_BLITTER_ASSERT_SVH
`define MASKED_SPRITE_BLITTER_ASSERT_SVH
`ifndef SYNTH
// Checked while reset is low.
`define MSB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("masked_sprite_blitter: assertion failed");
// Checked at every edge, reset included.
`define MSB_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("masked_sprite_blitter: assertion failed");
`else
`define MSB_ASSERT(name, clk, rst, prop)
`define MSB_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ----- hw/rtl/msblit_pkg.sv -----
// Shared types, sizes and codes of the masked sprite blitter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package msblit_pkg;

   // Store geometry.
   localparam int FRAME_WORDS  = 8192;
   localparam int SPRITE_ROWS  = 64;
   localparam int SPRITE_SLOTS = 16;

   localparam int FRAME_COLS = 32;
   localparam int SPR_COLS   = 4;
   localparam int SPR_WORDS  = SPRITE_ROWS * SPR_COLS;
   localparam int SPR_DEPTH  = SPRITE_SLOTS * SPR_WORDS;

   localparam int FRAME_AW = $clog2(FRAME_WORDS);
   localparam int SPR_AW   = $clog2(SPR_DEPTH);
   localparam int ROW_W    = $clog2(SPRITE_ROWS);
   localparam int COL_W    = $clog2(SPR_COLS);

   // Field widths fixed by the interface.
   localparam int PIX_W   = 16;
   localparam int SHIFT_W = 4;
   localparam int RAW_W   = 13;

   localparam int Q_DEPTH = 2;

   localparam logic [PIX_W-1:0] WORD_ONES = 16'hFFFF;
   localparam logic [PIX_W-1:0] WORD_ZERO = 16'h0000;

   localparam logic [1:0] OP_SPR_WRITE = 2'd0;
   localparam logic [1:0] OP_CLEAR     = 2'd1;
   localparam logic [1:0] OP_DRAW      = 2'd2;
   localparam logic [1:0] OP_READ      = 2'd3;

   typedef enum logic [2:0] {
      K_NOP,
      K_SPR_WRITE,
      K_CLEAR,
      K_DRAW,
      K_READ
   } kind_type;

   typedef enum logic [3:0] {
      B_INIT,
      B_IDLE,
      B_RDMEM,
      B_CLEAR,
      B_FETCH,
      B_LEFT,
      B_RIGHT,
      B_RESP
   } bstate_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [3:0]         sprite_slot;
      logic [7:0]         sprite_word_index;
      logic [PIX_W-1:0]   color_word;
      logic [PIX_W-1:0]   mask_word;
      logic [8:0]         pos_x;
      logic [7:0]         pos_y;
      logic               fill_white;
      logic [RAW_W-1:0]   frame_address;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] read_data;
      logic [1:0]       done_opcode;
   } rsp_type;

   // Classified command handed from the front end to the engine.
   typedef struct packed {
      kind_type             kind;
      logic [1:0]           opcode;
      logic [SPR_AW-1:0]    spr_addr;
      logic [PIX_W-1:0]     color;
      logic [PIX_W-1:0]     mask;
      logic [RAW_W-1:0]     raw_addr;
      logic [SHIFT_W-1:0]   shift;
      logic                 fill;
   } cmd_type;

endpackage

// ----- hw/rtl/msblit_front.sv -----
// Front end of the masked sprite blitter: takes request transfers and classifies them.
// Depends on msblit_pkg; feeds msblit_queue.
`timescale 1ns / 1ps

module msblit_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  msblit_pkg::req_type  req_data,
   input  logic                 q_full,
   input  logic                 init_busy,
   output logic                 push,
   output msblit_pkg::cmd_type  push_cmd
);

   logic                            slot_ok;
   logic                            idx_ok;
   logic [msblit_pkg::SPR_AW-1:0]   spr_base;

   assign req_stall = q_full | init_busy;
   assign push      = req_valid & ~req_stall;

   assign slot_ok  = 32'(req_data.sprite_slot) < msblit_pkg::SPRITE_SLOTS;
   assign idx_ok   = 32'(req_data.sprite_word_index) < msblit_pkg::SPR_WORDS;
   assign spr_base = msblit_pkg::SPR_AW'(32'(req_data.sprite_slot) * msblit_pkg::SPR_WORDS);

   always_comb begin
      push_cmd.kind     = msblit_pkg::K_NOP;
      push_cmd.opcode   = req_data.opcode;
      push_cmd.spr_addr = spr_base;
      push_cmd.color    = req_data.color_word;
      push_cmd.mask     = req_data.mask_word;
      push_cmd.raw_addr = req_data.frame_address;
      push_cmd.shift    = req_data.pos_x[3:0];
      push_cmd.fill     = req_data.fill_white;
      case (req_data.opcode)
         msblit_pkg::OP_SPR_WRITE: begin
            push_cmd.spr_addr = spr_base + msblit_pkg::SPR_AW'(req_data.sprite_word_index);
            if (slot_ok && idx_ok) begin
               push_cmd.kind = msblit_pkg::K_SPR_WRITE;
            end
         end
         msblit_pkg::OP_CLEAR: begin
            push_cmd.kind = msblit_pkg::K_CLEAR;
         end
         msblit_pkg::OP_DRAW: begin
            // Word base of the instance: row times 32 plus the tile column.
            push_cmd.raw_addr = {req_data.pos_y, req_data.pos_x[8:4]};
            if (slot_ok) begin
               push_cmd.kind = msblit_pkg::K_DRAW;
            end
         end
         msblit_pkg::OP_READ: begin
            push_cmd.kind = msblit_pkg::K_READ;
         end
         default: begin
            push_cmd.kind = msblit_pkg::K_NOP;
         end
      endcase
   end

endmodule

// ----- hw/rtl/msblit_queue.sv -----
// Short command queue between the blitter front end and its engine.
// Depends on msblit_pkg.
`timescale 1ns / 1ps

module msblit_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  msblit_pkg::cmd_type  push_cmd,
   output logic                 q_full,
   output logic                 q_valid,
   output msblit_pkg::cmd_type  q_cmd,
   input  logic                 q_pop
);

   localparam int PTR_W = (msblit_pkg::Q_DEPTH > 1) ? $clog2(msblit_pkg::Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(msblit_pkg::Q_DEPTH + 1);

   msblit_pkg::cmd_type entry_ff [msblit_pkg::Q_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign q_full  = (count_ff == CNT_W'(msblit_pkg::Q_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];
   assign do_push = push & ~q_full;
   assign do_pop  = q_pop & q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(msblit_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(msblit_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/msblit_back.sv -----
// Execution engine of the masked sprite blitter: owns the frame and sprite stores.
// Depends on msblit_pkg and masked_sprite_blitter_assert.svh; fed by msblit_queue.
`timescale 1ns / 1ps
`include "masked_sprite_blitter_assert.svh"

module msblit_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  msblit_pkg::cmd_type  q_cmd,
   output logic                 q_pop,
   output logic                 init_busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output msblit_pkg::rsp_type  rsp_data
);

   localparam int AW    = msblit_pkg::FRAME_AW;
   localparam int SUM_W = AW + 1;
   localparam int SAW   = msblit_pkg::SPR_AW;
   localparam int PW    = msblit_pkg::PIX_W;
   localparam logic [SUM_W-1:0] F_SUM = SUM_W'(msblit_pkg::FRAME_WORDS);
   localparam logic [PW-1:0] WORD_Z = msblit_pkg::WORD_ZERO;

   function automatic logic [AW-1:0] frame_wrap(input logic [SUM_W-1:0] sum);
      frame_wrap = (sum >= F_SUM) ? AW'(sum - F_SUM) : sum[AW-1:0];
   endfunction

   // Stores.
   logic [PW-1:0]   frm_mem [msblit_pkg::FRAME_WORDS];
   logic [2*PW-1:0] spr_mem [msblit_pkg::SPR_DEPTH];

   msblit_pkg::bstate_type       state_ff, state_in;
   msblit_pkg::cmd_type          cmd_ff, cmd_in;
   logic [AW-1:0]                cnt_ff, cnt_in;
   logic [AW-1:0]                row_ff, row_in;
   logic [msblit_pkg::COL_W-1:0] col_ff, col_in;
   logic [msblit_pkg::ROW_W-1:0] rowcnt_ff, rowcnt_in;
   logic [SAW-1:0]               saddr_ff, saddr_in;
   logic [AW-1:0]                left_ff, left_in;
   logic [AW-1:0]                right_ff, right_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   msblit_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic [PW-1:0]                frm_q_ff;
   logic [2*PW-1:0]              spr_q_ff;

   logic            frm_we, frm_re;
   logic [AW-1:0]   frm_wa, frm_ra;
   logic [PW-1:0]   frm_wd;
   logic            spr_we, spr_re;
   logic [SAW-1:0]  spr_wa, spr_ra;
   logic [2*PW-1:0] spr_wd;

   logic [AW-1:0]    left_now, right_now, row_step;
   logic [2*PW-1:0]  color_wide, mask_wide;
   logic [PW-1:0]    blend_left, blend_right;
   logic             adv;

   assign left_now  = frame_wrap({1'b0, row_ff} + SUM_W'(col_ff));
   assign right_now = frame_wrap({1'b0, row_ff} + SUM_W'(col_ff) + SUM_W'(1));
   assign row_step  = frame_wrap({1'b0, row_ff} + SUM_W'(msblit_pkg::FRAME_COLS));

   // Upper half is the left target shifted right, lower half the spill into the next word.
   assign color_wide  = {spr_q_ff[2*PW-1:PW], WORD_Z} >> cmd_ff.shift;
   assign mask_wide   = {spr_q_ff[PW-1:0], WORD_Z} >> cmd_ff.shift;
   assign blend_left  = (mask_wide[2*PW-1:PW] & color_wide[2*PW-1:PW])
                      | (~mask_wide[2*PW-1:PW] & frm_q_ff);
   assign blend_right = (mask_wide[PW-1:0] & color_wide[PW-1:0])
                      | (~mask_wide[PW-1:0] & frm_q_ff);

   assign init_busy = (state_ff == msblit_pkg::B_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rowcnt_in    = rowcnt_ff;
      saddr_in     = saddr_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      frm_we       = 1'b0;
      frm_wa       = left_ff;
      frm_wd       = blend_left;
      frm_re       = 1'b0;
      frm_ra       = left_ff;
      spr_we       = 1'b0;
      spr_wa       = q_cmd.spr_addr;
      spr_wd       = {q_cmd.color, q_cmd.mask};
      spr_re       = 1'b0;
      spr_ra       = saddr_ff;
      adv          = 1'b0;
      case (state_ff)
         msblit_pkg::B_INIT: begin
            frm_we = 1'b1;
            frm_wa = cnt_ff;
            frm_wd = msblit_pkg::WORD_ZERO;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(msblit_pkg::FRAME_WORDS - 1)) begin
               cnt_in   = '0;
               state_in = msblit_pkg::B_IDLE;
            end
         end
         msblit_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_cmd;
               cnt_in    = '0;
               // The frame size is a power of two, so the address wrap is a mask.
               row_in    = AW'(32'(q_cmd.raw_addr) % msblit_pkg::FRAME_WORDS);
               col_in    = '0;
               rowcnt_in = '0;
               saddr_in  = q_cmd.spr_addr;
               if (q_cmd.kind == msblit_pkg::K_SPR_WRITE) begin
                  spr_we   = 1'b1;
                  state_in = msblit_pkg::B_RESP;
               end else if (q_cmd.kind == msblit_pkg::K_CLEAR) begin
                  state_in = msblit_pkg::B_CLEAR;
               end else if (q_cmd.kind == msblit_pkg::K_DRAW) begin
                  state_in = msblit_pkg::B_FETCH;
               end else if (q_cmd.kind == msblit_pkg::K_READ) begin
                  state_in = msblit_pkg::B_RDMEM;
               end else begin
                  state_in = msblit_pkg::B_RESP;
               end
            end
         end
         msblit_pkg::B_RDMEM: begin
            frm_re   = 1'b1;
            frm_ra   = row_ff;
            state_in = msblit_pkg::B_RESP;
         end
         msblit_pkg::B_CLEAR: begin
            frm_we = 1'b1;
            frm_wa = cnt_ff;
            frm_wd = cmd_ff.fill ? msblit_pkg::WORD_ONES : msblit_pkg::WORD_ZERO;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(msblit_pkg::FRAME_WORDS - 1)) begin
               cnt_in   = '0;
               state_in = msblit_pkg::B_RESP;
            end
         end
         msblit_pkg::B_FETCH: begin
            spr_re   = 1'b1;
            spr_ra   = saddr_ff;
            frm_re   = 1'b1;
            frm_ra   = left_now;
            left_in  = left_now;
            right_in = right_now;
            state_in = msblit_pkg::B_LEFT;
         end
         msblit_pkg::B_LEFT: begin
            frm_we = 1'b1;
            frm_wa = left_ff;
            frm_wd = blend_left;
            if (cmd_ff.shift != '0) begin
               frm_re   = 1'b1;
               frm_ra   = right_ff;
               state_in = msblit_pkg::B_RIGHT;
            end else begin
               adv = 1'b1;
            end
         end
         msblit_pkg::B_RIGHT: begin
            frm_we = 1'b1;
            frm_wa = right_ff;
            frm_wd = blend_right;
            adv    = 1'b1;
         end
         msblit_pkg::B_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.read_data   = (cmd_ff.kind == msblit_pkg::K_READ) ? frm_q_ff
                                                                             : WORD_Z;
               rsp_data_in.done_opcode = cmd_ff.opcode;
               state_in                = msblit_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = msblit_pkg::B_IDLE;
         end
      endcase

      // Step to the next sprite word in row-major order.
      if (adv) begin
         saddr_in = saddr_ff + 1'b1;
         state_in = msblit_pkg::B_FETCH;
         if (col_ff == msblit_pkg::COL_W'(msblit_pkg::SPR_COLS - 1)) begin
            col_in    = '0;
            row_in    = row_step;
            rowcnt_in = rowcnt_ff + 1'b1;
            if (rowcnt_ff == msblit_pkg::ROW_W'(msblit_pkg::SPRITE_ROWS - 1)) begin
               state_in = msblit_pkg::B_RESP;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msblit_pkg::B_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      rowcnt_ff   <= rowcnt_in;
      saddr_ff    <= saddr_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (frm_we) begin
         frm_mem[frm_wa] <= frm_wd;
      end
      if (frm_re) begin
         frm_q_ff <= frm_mem[frm_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (spr_we) begin
         spr_mem[spr_wa] <= spr_wd;
      end
      if (spr_re) begin
         spr_q_ff <= spr_mem[spr_ra];
      end
   end

   `MSB_ASSERT(a_frm_write_states, clock, reset, frm_we |-> (state_ff == msblit_pkg::B_INIT || state_ff == msblit_pkg::B_CLEAR || state_ff == msblit_pkg::B_LEFT || state_ff == msblit_pkg::B_RIGHT))
   `MSB_ASSERT(a_no_same_addr, clock, reset, (frm_we && frm_re) |-> (frm_wa != frm_ra))
   `MSB_ASSERT(a_spill_follows, clock, reset, (state_ff == msblit_pkg::B_LEFT && cmd_ff.shift != '0) |=> (state_ff == msblit_pkg::B_RIGHT))
   `MSB_ASSERT(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == msblit_pkg::B_RESP))
   `MSB_ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset) |-> !rsp_valid_ff)

endmodule

// ----- hw/rtl/masked_sprite_blitter.sv -----
// Masked sprite blitter, one bit per pixel, top level. One item is in the engine at a time:
// the engine takes no new item before it is through with the last one, and two more can
// wait in the command queue. Reset is synchronous, active high; then the frame is cleared
// while req_stall is held high.
`timescale 1ns / 1ps

module masked_sprite_blitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  msblit_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output msblit_pkg::rsp_type  rsp_data
);

   // The block splits into three parts. The front end decodes each request transfer:
   // it checks the sprite slot and word index, folds out-of-range sprite writes and
   // draws into no-op commands, and forms the sprite store address and the raw frame
   // word base. The queue holds classified commands so the request side keeps taking
   // transfers while the engine works, until it is full. The engine runs one command at a
   // time and writes its result into an output register that the response side drains.
   //
   // The engine's cost is set by the frame store, which has one read and one write port. The
   // frame size is a power of two, so wrapping a frame address costs no time. A draw fetches
   // each sprite word and blends it into the left target, with one more step for the spill
   // into the next word when the instance is not tile aligned. A clear writes one frame word
   // per cycle.

   logic                 push;
   msblit_pkg::cmd_type  push_cmd;
   logic                 q_full;
   logic                 q_valid;
   msblit_pkg::cmd_type  q_cmd;
   logic                 q_pop;
   logic                 init_busy;

   msblit_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .init_busy (init_busy),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   msblit_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop)
   );

   // The engine only presents a result when its output register is free or the
   // held result leaves in the same cycle, so no transfer is ever overwritten.
   msblit_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/sv/masked_sprite_blitter_checker.sv -----
// Result checker for the masked sprite blitter: predicts each transfer's result from
// its own copy of the sprite and frame stores and compares it with what comes out.
// Depends on msblit_pkg for the payload types, store sizes and opcodes.
`timescale 1ns / 1ps

module masked_sprite_blitter_checker
   import msblit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      outstanding
);

   logic [31:0]      sprite_words [SPR_DEPTH];
   logic [PIX_W-1:0] frame_words [FRAME_WORDS];
   rsp_type          due_results [$];
   int               failures = 0;

   function automatic void blend_word(input logic [FRAME_AW-1:0] addr,
                                      input logic [PIX_W-1:0] color,
                                      input logic [PIX_W-1:0] mask);
      frame_words[addr] = (mask & color) | (~mask & frame_words[addr]);
   endfunction

   // Applies one command to the local stores and returns the result it must produce.
   function automatic rsp_type run_command(input req_type cmd);
      rsp_type             done;
      int                  base;
      int                  r;
      int                  c;
      logic [FRAME_AW-1:0] addr;
      logic [SHIFT_W-1:0]  shift;
      logic [31:0]         word;
      done.read_data   = WORD_ZERO;
      done.done_opcode = cmd.opcode;
      case (cmd.opcode)
         OP_SPR_WRITE: begin
            if (cmd.sprite_slot < SPRITE_SLOTS && cmd.sprite_word_index < SPR_WORDS)
               sprite_words[cmd.sprite_slot * SPR_WORDS + cmd.sprite_word_index] =
                  {cmd.color_word, cmd.mask_word};
         end
         OP_CLEAR: begin
            foreach (frame_words[i])
               frame_words[i] = cmd.fill_white ? WORD_ONES : WORD_ZERO;
         end
         OP_DRAW: begin
            if (cmd.sprite_slot < SPRITE_SLOTS) begin
               base  = cmd.pos_y * FRAME_COLS + (cmd.pos_x >> 4);
               shift = cmd.pos_x[3:0];
               for (r = 0; r < SPRITE_ROWS; r++) begin
                  for (c = 0; c < SPR_COLS; c++) begin
                     word = sprite_words[cmd.sprite_slot * SPR_WORDS + r * SPR_COLS + c];
                     addr = FRAME_AW'((base + r * FRAME_COLS + c) % FRAME_WORDS);
                     blend_word(addr, word[31:16] >> shift, word[15:0] >> shift);
                     if (shift != 0)
                        blend_word(FRAME_AW'(addr + 1), word[31:16] << (PIX_W - shift),
                                   word[15:0] << (PIX_W - shift));
                  end
               end
            end
         end
         OP_READ: begin
            done.read_data = frame_words[cmd.frame_address % FRAME_WORDS];
         end
         default: ;
      endcase
      return done;
   endfunction

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      failures++;
      if (failures <= 10)
         $display("%0t ns: %s: expected read_data %h done_opcode %0d, got read_data %h done_opcode %0d",
                  $time, what, want.read_data, want.done_opcode, got.read_data, got.done_opcode);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         due_results.delete();
         foreach (frame_words[i]) frame_words[i] = WORD_ZERO;
         foreach (sprite_words[i]) sprite_words[i] = '0;
      end else begin
         if (rsp_valid && rsp_stall === 1'b0) begin
            if (due_results.size() == 0) begin
               report_mismatch("result with nothing expected", '0, rsp_data);
            end else begin
               want = due_results.pop_front();
               if (rsp_data.done_opcode !== want.done_opcode)
                  report_mismatch("done_opcode mismatch", want, rsp_data);
               else if (rsp_data.read_data !== want.read_data)
                  report_mismatch("read_data mismatch", want, rsp_data);
            end
         end
         if (req_valid && req_stall === 1'b0)
            due_results.push_back(run_command(req_data));
      end
      outstanding    <= due_results.size();
      mismatch_count <= failures;
   end

endmodule

// ----- tb/sv/masked_sprite_blitter_test.sv -----
// Top of the masked sprite blitter testbench: clock, reset, stimulus, receiver stalls,
// watchdog and the final verdict. Depends on msblit_pkg, the blitter and its checker.
`timescale 1ns / 1ps

module masked_sprite_blitter_test;
   import msblit_pkg::*;

   // Random part length, the long receiver hold-off, and the watchdog limit. The longest
   // quiet stretch of a correct run is a frame clear on top of a hold-off and a long gap, so
   // the limit leaves a wide margin over that.
   localparam int RANDOM_ITEMS = 1000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int IDLE_LIMIT   = 40000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int outstanding;
   int idle_cycles = 0;

   // Which sprite words have been loaded. A draw reads all words of its slot, so only
   // fully loaded slots are ever drawn.
   bit sprite_loaded [SPRITE_SLOTS][SPR_WORDS];
   int words_loaded [SPRITE_SLOTS];
   int fill_next = SPR_WORDS;   // next word of the sequential load, slot 1 onward
   int last_base = 0;           // frame word of the latest draw, to aim reads at
   bit calm = 1'b0;             // when set, the sender offers back to back

   masked_sprite_blitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   masked_sprite_blitter_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Gap after a transfer: mostly none or short, now and then long, and none at all
   // while the sender is in a calm stretch.
   function automatic int pick_gap();
      int roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   // Every item starts as random noise so that the fields an opcode ignores still toggle.
   function automatic req_type scrambled_item();
      req_type item;
      item.opcode            = 2'($urandom);
      item.sprite_slot       = 4'($urandom);
      item.sprite_word_index = 8'($urandom);
      item.color_word        = PIX_W'($urandom);
      item.mask_word         = PIX_W'($urandom);
      item.pos_x             = 9'($urandom);
      item.pos_y             = 8'($urandom);
      item.fill_white        = 1'($urandom);
      item.frame_address     = RAW_W'($urandom);
      return item;
   endfunction

   function automatic req_type write_item(input int slot, input int index,
                                          input logic [PIX_W-1:0] color,
                                          input logic [PIX_W-1:0] mask);
      req_type item;
      item                   = scrambled_item();
      item.opcode            = OP_SPR_WRITE;
      item.sprite_slot       = 4'(slot);
      item.sprite_word_index = 8'(index);
      item.color_word        = color;
      item.mask_word         = mask;
      if (!sprite_loaded[slot][index]) begin
         sprite_loaded[slot][index] = 1'b1;
         words_loaded[slot]++;
      end
      return item;
   endfunction

   function automatic req_type draw_item(input int slot, input int x, input int y);
      req_type item;
      item             = scrambled_item();
      item.opcode      = OP_DRAW;
      item.sprite_slot = 4'(slot);
      item.pos_x       = 9'(x);
      item.pos_y       = 8'(y);
      last_base        = (y * FRAME_COLS + x / 16) % FRAME_WORDS;
      return item;
   endfunction

   function automatic req_type read_item(input int addr);
      req_type item;
      item               = scrambled_item();
      item.opcode        = OP_READ;
      item.frame_address = RAW_W'(addr);
      return item;
   endfunction

   function automatic req_type clear_item(input logic white);
      req_type item;
      item            = scrambled_item();
      item.opcode     = OP_CLEAR;
      item.fill_white = white;
      return item;
   endfunction

   // Offers one item and holds it until the transfer happens. With no gap the next call
   // overwrites the payload at the same edge, so valid simply stays high.
   task automatic send(input req_type item);
      int gap;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      if ($urandom_range(0, 99) == 0)
         calm = !calm;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int roll;
      int slot;
      int x;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Load sprite slot 0 completely, since any draw reads the whole slot. The first
      // words carry the extremes: opaque white, opaque black, fully transparent, and
      // a checkered mask.
      send(write_item(0, 0, WORD_ONES, WORD_ONES));
      send(write_item(0, 1, WORD_ZERO, WORD_ONES));
      send(write_item(0, 2, WORD_ONES, WORD_ZERO));
      send(write_item(0, 3, 16'hAAAA, 16'h0F0F));
      for (int i = 4; i < SPR_WORDS; i++)
         send(write_item(0, i, PIX_W'($urandom), PIX_W'($urandom)));

      // Directed part: both clear colors, reads at both ends of the frame, an aligned
      // draw, the largest shift at the bottom right corner where both the right spill
      // and the rows below the frame wrap, small and middle shifts, and writes with the
      // largest slot and word index.
      send(read_item(0));
      send(clear_item(1'b1));
      send(read_item(FRAME_WORDS - 1));
      send(draw_item(0, 0, 0));
      send(read_item(0));
      send(read_item(1));
      send(read_item(63 * FRAME_COLS + 3));
      send(draw_item(0, 511, 255));
      send(read_item(FRAME_WORDS - 1));
      send(read_item(0));
      send(read_item(62 * FRAME_COLS + 2));
      send(read_item(62 * FRAME_COLS + 3));
      send(draw_item(0, 1, 10));
      send(read_item(10 * FRAME_COLS));
      send(read_item(10 * FRAME_COLS + 4));
      send(draw_item(0, 88, 100));
      send(read_item(100 * FRAME_COLS + 5));
      send(read_item(100 * FRAME_COLS + 9));
      send(clear_item(1'b0));
      send(read_item(4095));
      send(write_item(15, 255, WORD_ONES, WORD_ONES));
      send(write_item(15, 0, WORD_ZERO, WORD_ZERO));
      send(draw_item(0, 15, 0));
      send(read_item(0));
      send(read_item(1));

      // Random part. Sprite writes mostly continue a sequential load so that more slots
      // become drawable; the rest rewrite random words. Reads mostly land on the area
      // the latest draw touched, where the frame actually holds something.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            send(clear_item(1'($urandom)));
         end else if (roll < 45) begin
            if ($urandom_range(0, 4) != 0 && fill_next < SPR_DEPTH) begin
               send(write_item(fill_next / SPR_WORDS, fill_next % SPR_WORDS,
                               PIX_W'($urandom), PIX_W'($urandom)));
               fill_next++;
            end else begin
               send(write_item($urandom_range(0, SPRITE_SLOTS - 1),
                               $urandom_range(0, SPR_WORDS - 1),
                               PIX_W'($urandom), PIX_W'($urandom)));
            end
         end else if (roll < 70) begin
            do slot = $urandom_range(0, SPRITE_SLOTS - 1);
            while (words_loaded[slot] != SPR_WORDS);
            x = $urandom_range(0, 511);
            if ($urandom_range(0, 2) == 0)
               x = x & ~15;
            send(draw_item(slot, x, $urandom_range(0, 255)));
         end else if ($urandom_range(0, 9) < 7) begin
            send(read_item((last_base + $urandom_range(0, SPRITE_ROWS - 1) * FRAME_COLS
                            + $urandom_range(0, SPR_COLS)) % FRAME_WORDS));
         end else begin
            send(read_item($urandom_range(0, FRAME_WORDS - 1)));
         end
      end
      req_valid <= 1'b0;

      // The count of waiting results is registered, so it lags behind the last transfer.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("** masked_sprite_blitter: PASSED **");
      else
         $display("** masked_sprite_blitter: FAILED **");
      $finish;
   end

   // Receiver: alternates free and stalled stretches of random length. Twice in the run,
   // after 400 and 800 results, it holds off for a long stretch while the sender keeps
   // offering, so the command queue fills and the block stalls its input.
   initial begin : receiver
      int  phase_left = 0;
      bit  stalling   = 1'b0;
      int  holds_done = 0;
      int  taken      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_stall === 1'b0)
            taken++;
         if (phase_left == 0) begin
            if (holds_done < 2 && taken >= 400 * (holds_done + 1)) begin
               stalling   = 1'b1;
               phase_left = HOLD_CYCLES;
               holds_done++;
            end else if (stalling || $urandom_range(0, 99) < 40) begin
               stalling   = 1'b0;
               phase_left = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 300)
                                                         : $urandom_range(1, 8);
            end else begin
               stalling   = 1'b1;
               phase_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4)
                                                         : $urandom_range(15, 60);
            end
         end
         rsp_stall <= stalling;
         phase_left--;
      end
   end

   // Watchdog: counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** masked_sprite_blitter: FAILED **");
            $finish;
         end
      end
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/msblit_pkg.sv
hw/rtl/msblit_front.sv
hw/rtl/msblit_queue.sv
hw/rtl/msblit_back.sv
hw/rtl/masked_sprite_blitter.sv
tb/sv/masked_sprite_blitter_checker.sv
tb/sv/masked_sprite_blitter_test.sv
